// ----- rtl/sem_pkg.sv -----
// sem_pkg: shared widths, register indexes and lane structs for the sobel edge block
// no dependencies; imported by every module under rtl
package sem_pkg;

  // pixel, configuration and arithmetic widths
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 2 * GRAD_W;
  localparam int ENERGY_W   = 21;
  localparam int ROOT_W     = 8;
  localparam int ROOT_IN_W  = 2 * ROOT_W;
  localparam int SAT_LIMIT  = 65025;
  localparam int MIN_DIM    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // gradient pair handed from the window to the energy stage
  typedef struct packed {
    logic                     valid;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     frame_done;
  } grad_t;

  // one slot of the square root cell chain
  typedef struct packed {
    logic                 valid;
    logic [ROOT_IN_W-1:0] e;
    logic                 sat;
    logic [ROOT_W-1:0]    r;
    logic                 frame_done;
  } root_lane_t;

endpackage

// ----- rtl/sobel_edge_magnitude_top.sv -----
// sobel_edge_magnitude_top: streaming 3x3 sobel edge magnitude with a square root cell chain
// depends on sem_pkg, sem_line_window and sem_root_cell
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+-----------
//  input   | in_valid, in_stall, in_pixel_value,      | in
//          | in_start_of_frame                        |
//  result  | out_valid, out_stall, out_edge_magnitude,| out
//          | out_frame_done                           |
//  config  | cfg_wr_en, cfg_index, cfg_wdata          | in
//
// one pixel per clock sustained unless out_stall holds the pipeline; the line stores are
// read and written once per cycle; from input transaction to out_valid the registers are
// the line store read, gradients, energy squares, eight root cells and the rounding stage
// rst_n is synchronous; line store contents are left as they are
// out_stall while a result is held freezes the whole pipeline and raises in_stall
module sobel_edge_magnitude_top import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH   = 1024,
  parameter int MAX_FRAME_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel_value,
  input  logic                 in_start_of_frame,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ROOT_W-1:0]    out_edge_magnitude,
  output logic                 out_frame_done,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic               adv_en;
  logic [CFG_W-1:0]   width_r, height_r;
  logic [CFG_W-1:0]   width_clamp, height_clamp;
  grad_t              grad;

  logic signed [SQ_W-1:0] sqx, sqy;
  logic [ENERGY_W-1:0]    energy;
  root_lane_t             lane_in_r;
  root_lane_t             lanes [ROOT_W+1];

  logic [ROOT_IN_W-1:0] root_sq;
  logic [ROOT_W-1:0]    root_ceil;
  logic                 out_valid_r;
  logic [ROOT_W-1:0]    out_mag_r;
  logic                 out_fd_r;

  // whole pipeline moves unless a held result is stalled
  assign adv_en   = !(out_valid_r && out_stall);
  assign in_stall = !adv_en;

  // clamp written sizes into the supported range
  always_comb begin
    if (32'(cfg_wdata) < MIN_DIM) begin
      width_clamp  = CFG_W'(MIN_DIM);
      height_clamp = CFG_W'(MIN_DIM);
    end else begin
      width_clamp  = (32'(cfg_wdata) > MAX_LINE_WIDTH)   ? CFG_W'(MAX_LINE_WIDTH)   : cfg_wdata;
      height_clamp = (32'(cfg_wdata) > MAX_FRAME_HEIGHT) ? CFG_W'(MAX_FRAME_HEIGHT) : cfg_wdata;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= (MAX_LINE_WIDTH > 1024)   ? CFG_W'(1024) : CFG_W'(MAX_LINE_WIDTH);
      height_r <= (MAX_FRAME_HEIGHT > 1024) ? CFG_W'(1024) : CFG_W'(MAX_FRAME_HEIGHT);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= width_clamp;
        REG_IMAGE_HEIGHT: height_r <= height_clamp;
        default: ;
      endcase
    end
  end

  sem_line_window #(
    .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv_en         (adv_en),
    .in_valid       (in_valid),
    .pixel_value    (in_pixel_value),
    .start_of_frame (in_start_of_frame),
    .image_width    (width_r),
    .image_height   (height_r),
    .grad_o         (grad)
  );

  // gradient energy and saturation check
  always_comb begin
    sqx    = SQ_W'(grad.gx) * SQ_W'(grad.gx);
    sqy    = SQ_W'(grad.gy) * SQ_W'(grad.gy);
    energy = $unsigned(sqx[ENERGY_W-1:0]) + $unsigned(sqy[ENERGY_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_in_r.valid <= 1'b0;
    end else if (adv_en) begin
      lane_in_r.valid      <= grad.valid;
      lane_in_r.e          <= energy[ROOT_IN_W-1:0];
      lane_in_r.sat        <= energy > ENERGY_W'(SAT_LIMIT);
      lane_in_r.r          <= '0;
      lane_in_r.frame_done <= grad.frame_done;
    end
  end

  assign lanes[0] = lane_in_r;

  // root cells, most significant bit first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    sem_root_cell #(
      .BIT_POS (ROOT_W - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv_en (adv_en),
      .lane_i (lanes[k]),
      .lane_o (lanes[k+1])
    );
  end

  // round the floor root up and apply saturation
  always_comb begin
    root_sq   = {{ROOT_W{1'b0}}, lanes[ROOT_W].r} * {{ROOT_W{1'b0}}, lanes[ROOT_W].r};
    root_ceil = (root_sq < lanes[ROOT_W].e) ? lanes[ROOT_W].r + ROOT_W'(1) : lanes[ROOT_W].r;
    if (lanes[ROOT_W].sat) begin
      root_ceil = '1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_en) begin
      out_valid_r <= lanes[ROOT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_en) begin
      out_mag_r <= root_ceil;
      out_fd_r  <= lanes[ROOT_W].frame_done;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_edge_magnitude = out_mag_r;
  assign out_frame_done     = out_fd_r;

`ifndef SYNTH
  // saturated energy always leaves as full scale
  a_sat_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_en && lanes[ROOT_W].valid && lanes[ROOT_W].sat) |=>
      (out_valid && (out_edge_magnitude == '1)))
    else $error("saturated result is not full scale");

  // a stalled result freezes the input side as well
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result is stalled");
`endif

endmodule

// ----- rtl/sem_root_cell.sv -----
// sem_root_cell: one bit of the pipelined integer square root
// depends on sem_pkg (root_lane_t, widths)
module sem_root_cell import sem_pkg::*; #(
  parameter int BIT_POS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv_en,
  input  root_lane_t lane_i,
  output root_lane_t lane_o
);

  root_lane_t           lane_r;
  root_lane_t           lane_nxt;
  logic [ROOT_W-1:0]    trial;
  logic [ROOT_IN_W-1:0] trial_sq;

  // try setting this bit, keep it if the square still fits
  always_comb begin
    trial    = lane_i.r | (ROOT_W'(1) << BIT_POS);
    trial_sq = {{ROOT_W{1'b0}}, trial} * {{ROOT_W{1'b0}}, trial};
    lane_nxt = lane_i;
    if (trial_sq <= lane_i.e) begin
      lane_nxt.r = trial;
    end
  end

  // hand the lane to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (adv_en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

`ifndef SYNTH
  // the partial root never overshoots the energy
  a_root_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_en && lane_i.valid && !lane_i.sat) |=>
      (({{ROOT_W{1'b0}}, lane_o.r} * {{ROOT_W{1'b0}}, lane_o.r}) <= lane_o.e))
    else $error("root cell partial root exceeds energy");
`endif

endmodule

// ----- rtl/sem_line_window.sv -----
// sem_line_window: position counters, two line stores, 3x3 window and sobel gradients
// depends on sem_pkg (grad_t, widths)
module sem_line_window import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH   = 1024,
  parameter int MAX_FRAME_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv_en,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] pixel_value,
  input  logic             start_of_frame,
  input  logic [CFG_W-1:0] image_width,
  input  logic [CFG_W-1:0] image_height,
  output grad_t            grad_o
);

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W = $clog2(MAX_FRAME_HEIGHT);

  logic             acc;
  logic [COL_W-1:0] col_r, col_nxt, col_base, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_base, row_cur;
  logic             last_col;
  logic             interior;
  logic             last_pix;

  // first stage: pixel waiting for line store data
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_int_r;
  logic             s1_fd_r;

  logic [PIX_W-1:0] upper_mem [MAX_LINE_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_LINE_WIDTH];
  logic [PIX_W-1:0] upper_rd_r, middle_rd_r;
  logic             fwd_hit_r;
  logic [PIX_W-1:0] fwd_top_r, fwd_mid_r;
  logic [PIX_W-1:0] top_eff, mid_eff;

  logic [PIX_W-1:0] win_r [6];

  logic signed [GRAD_W-1:0] t0, m0, b0, t1, b1, t2, m2, b2;
  logic signed [GRAD_W-1:0] gx, gy;
  grad_t                    grad_r;

  assign acc = in_valid && adv_en;

  // position of the incoming pixel after start flag and wrap rules
  always_comb begin
    col_base = start_of_frame ? '0 : col_r;
    row_base = start_of_frame ? '0 : row_r;
    col_cur  = (32'(col_base) >= 32'(image_width))  ? '0 : col_base;
    row_cur  = (32'(row_base) >= 32'(image_height)) ? '0 : row_base;
    last_col = (32'(col_cur) + 32'd1) >= 32'(image_width);
    interior = (32'(row_cur) >= 32'd2) && (32'(col_cur) >= 32'd2);
    last_pix = (32'(row_cur) == 32'(image_height) - 32'd1) && last_col;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = ((32'(row_cur) + 32'd1) >= 32'(image_height)) ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // first stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_en) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r <= col_cur;
      s1_pix_r <= pixel_value;
      s1_int_r <= interior;
      s1_fd_r  <= last_pix;
    end
  end

  // line stores: write the retiring column, read the incoming one
  always_ff @(posedge clk) begin
    if (adv_en) begin
      if (s1_valid_r) begin
        upper_mem[s1_col_r]  <= mid_eff;
        middle_mem[s1_col_r] <= s1_pix_r;
      end
      upper_rd_r  <= upper_mem[col_cur];
      middle_rd_r <= middle_mem[col_cur];
    end
  end

  // bypass when the incoming pixel reads the column being written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (adv_en) begin
      fwd_hit_r <= s1_valid_r && (s1_col_r == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_en) begin
      fwd_top_r <= mid_eff;
      fwd_mid_r <= s1_pix_r;
    end
  end

  assign top_eff = fwd_hit_r ? fwd_top_r : upper_rd_r;
  assign mid_eff = fwd_hit_r ? fwd_mid_r : middle_rd_r;

  // window columns shift by one per pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv_en && s1_valid_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_eff;
      win_r[4] <= mid_eff;
      win_r[5] <= s1_pix_r;
    end
  end

  // sobel x and y kernels
  always_comb begin
    t0 = $signed({3'b000, win_r[0]});
    m0 = $signed({3'b000, win_r[1]});
    b0 = $signed({3'b000, win_r[2]});
    t1 = $signed({3'b000, win_r[3]});
    b1 = $signed({3'b000, win_r[5]});
    t2 = $signed({3'b000, top_eff});
    m2 = $signed({3'b000, mid_eff});
    b2 = $signed({3'b000, s1_pix_r});
    gx = (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
    gy = (b0 - t0) + ((b1 - t1) <<< 1) + (b2 - t2);
  end

  // gradient register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_r.valid <= 1'b0;
    end else if (adv_en) begin
      grad_r.valid      <= s1_valid_r && s1_int_r;
      grad_r.gx         <= gx;
      grad_r.gy         <= gy;
      grad_r.frame_done <= s1_fd_r;
    end
  end

  assign grad_o = grad_r;

`ifndef SYNTH
  // a start flag always lands the pixel on column zero
  a_sof_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && start_of_frame) |=> (s1_valid_r && (s1_col_r == '0)))
    else $error("start of frame did not reset the column");

  // interior pixels are never in the first two columns
  a_interior_col: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_int_r) |-> (32'(s1_col_r) >= 32'd2))
    else $error("interior flag set on a border column");
`endif

endmodule

// ----- test/sobel_edge_checker.sv -----
// sobel_edge_checker: watches the pixel, result and configuration ports of the sobel edge block,
// predicts every edge magnitude and compares each result transaction with the oldest prediction
// depends on sem_pkg for port widths
module sobel_edge_checker import sem_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel_value,
  input  logic                 in_start_of_frame,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ROOT_W-1:0]    out_edge_magnitude,
  input  logic                 out_frame_done,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX   = 1024;
  localparam int unsigned HEIGHT_MAX = 1024;
  localparam int unsigned ENERGY_CAP = 255 * 255;

  typedef struct packed {
    logic [ROOT_W-1:0] magnitude;
    logic              frame_done;
  } edge_result_t;

  // predictor state: two line stores, the two trailing window columns, raster position
  logic [PIX_W-1:0] upper_line [LINE_MAX];
  logic [PIX_W-1:0] middle_line [LINE_MAX];
  logic [PIX_W-1:0] window_px [6];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      line_width;
  int unsigned      frame_height;

  edge_result_t expected_edges [$];
  edge_result_t want;
  int           fail_total = 0;
  int           queued = 0;

  assign mismatch_count  = fail_total;
  assign results_pending = queued;

  // out-of-range sizes are pinned to the legal span
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // smallest root whose square covers the energy, pinned at 255
  function automatic logic [ROOT_W-1:0] ceil_root_sat(input int unsigned energy);
    if (energy > ENERGY_CAP) return 8'd255;
    for (int k = 0; k < 256; k++) begin
      if (int'(k * k) >= 0 && k * k >= energy) return 8'(k);
    end
    return 8'd255;
  endfunction

  // one accepted pixel: maybe one expected edge result, then shift window and stores
  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    int unsigned  c;
    int unsigned  r;
    logic [7:0]   top_px;
    logic [7:0]   mid_px;
    int           gx;
    int           gy;
    int unsigned  energy;
    edge_result_t res;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= line_width) col_pos = 0;
    if (row_pos >= frame_height) row_pos = 0;
    c = col_pos;
    r = row_pos;
    top_px = upper_line[c];
    mid_px = middle_line[c];
    if (r >= 2 && c >= 2) begin
      gx = (int'(top_px) - int'(window_px[0])) + 2 * (int'(mid_px) - int'(window_px[1]))
         + (int'(pix) - int'(window_px[2]));
      gy = (int'(window_px[2]) - int'(window_px[0]))
         + 2 * (int'(window_px[5]) - int'(window_px[3]))
         + (int'(pix) - int'(top_px));
      energy = int'(gx * gx) + int'(gy * gy);
      res.magnitude  = ceil_root_sat(energy);
      res.frame_done = (r == frame_height - 1) && (c == line_width - 1);
      expected_edges.push_back(res);
    end
    window_px[0] = window_px[3];
    window_px[1] = window_px[4];
    window_px[2] = window_px[5];
    window_px[3] = top_px;
    window_px[4] = mid_px;
    window_px[5] = pix;
    upper_line[c]  = mid_px;
    middle_line[c] = pix;
    if (c + 1 >= line_width) begin
      col_pos = 0;
      row_pos = (r + 1 >= frame_height) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // sample every channel at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) window_px[i] = '0;
      for (int i = 0; i < LINE_MAX; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      col_pos      = 0;
      row_pos      = 0;
      line_width   = LINE_MAX;
      frame_height = HEIGHT_MAX;
      expected_edges.delete();
    end else begin
      if (in_valid && !in_stall) predict_pixel(in_pixel_value, in_start_of_frame);

      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_edges.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result, expected none, got magnitude %0d frame_done %0d",
                   $time, out_edge_magnitude, out_frame_done);
        end else begin
          want = expected_edges.pop_front();
          if (out_edge_magnitude !== want.magnitude) begin
            fail_total++;
            $display("%0t: edge_magnitude mismatch, expected %0d, got %0d",
                     $time, want.magnitude, out_edge_magnitude);
          end
          if (out_frame_done !== want.frame_done) begin
            fail_total++;
            $display("%0t: frame_done mismatch, expected %0d, got %0d",
                     $time, want.frame_done, out_frame_done);
          end
        end
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            line_width = clamp_dim(cfg_wdata, LINE_MAX);
          end
          REG_IMAGE_HEIGHT: begin
            frame_height = clamp_dim(cfg_wdata, HEIGHT_MAX);
          end
          default: begin
          end
        endcase
      end
    end
    queued = expected_edges.size();
  end

endmodule

// ----- test/sobel_edge_magnitude_top_test.sv -----
// sobel_edge_magnitude_top_test: clock, reset, pixel stimulus, result back-pressure and verdict
// depends on sem_pkg, sobel_edge_magnitude_top and sobel_edge_checker
module sobel_edge_magnitude_top_test;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 700;
  localparam int PROBE_ITEMS  = 48;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 3000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_value = '0;
  logic                 in_start_of_frame = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROOT_W-1:0]    out_edge_magnitude;
  logic                 out_frame_done;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int mismatch_count;
  int results_pending;
  int cycle_count = 0;
  int walk_level = 128;
  bit burst_mode = 1'b0;
  bit hold_req = 1'b0;

  sobel_edge_magnitude_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel_value     (in_pixel_value),
    .in_start_of_frame  (in_start_of_frame),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_edge_magnitude (out_edge_magnitude),
    .out_frame_done     (out_frame_done),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  sobel_edge_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel_value     (in_pixel_value),
    .in_start_of_frame  (in_start_of_frame),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_edge_magnitude (out_edge_magnitude),
    .out_frame_done     (out_frame_done),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // pixel content: uniform, black and white only, or a slow walk
  function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
    case (mode)
      0: begin
        return PIX_W'($urandom_range(0, 255));
      end
      1: begin
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        walk_level = walk_level + $urandom_range(0, 6) - 3;
        if (walk_level < 0) walk_level = 0;
        if (walk_level > 255) walk_level = 255;
        return 8'(walk_level);
      end
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CFG_W'($urandom_range(0, 2));
    if (r == 1) return CFG_W'($urandom_range(13, 40));
    return CFG_W'($urandom_range(3, 12));
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, 2));
    return CFG_W'($urandom_range(3, 8));
  endfunction

  // one pixel transaction, held until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_pixel_value    <= pix;
    in_start_of_frame <= sof;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // stop offering, wait for every expected result and the pipeline tail
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // a run of pixels; first one may open a frame, later ones may restart it at random
  task automatic run_phase(input int n_items, input bit open_frame, input int mode,
                           input bit sof_noise, input int hold_at);
    logic sof;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      sof = (i == 0) ? open_frame : (sof_noise && $urandom_range(0, 39) == 0);
      send_pixel(pick_pixel(mode), sof);
    end
  endtask

  // result side: runs of stall and free cycles, plus one long hold-off on request
  initial begin : result_sink
    int run_left;
    int hold_cnt;
    int r;
    bit hold_done;
    run_left  = 0;
    hold_cnt  = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) begin
          hold_done = 1'b1;
          run_left  = 0;
        end
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(0, 7);
        end else if (r < 62) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(40, 120);
        end else if (r < 94) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          run_left = $urandom_range(8, 30);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin : pixel_source
    int  random_items;
    int  n;
    int  choice;
    bit  width_written;
    bit  first_phase;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // smallest frame, sizes written below the minimum
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, 11'd0);
    burst_mode = 1'b1;
    // hard vertical edge, horizontal gradient saturates
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'hFF : 8'h00, i == 0);
    // hard horizontal edge, vertical gradient saturates
    for (int i = 0; i < 9; i++) send_pixel((i < 3) ? 8'h00 : ((i < 6) ? 8'h80 : 8'hFF), i == 0);
    // flat frame entered by wrap-around with no start flag
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 1'b0);
    settle();

    // random phases over small frames
    random_items = 0;
    first_phase  = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      width_written = 1'b0;
      choice = $urandom_range(0, 9);
      if (choice < 7 || first_phase) begin
        write_reg(REG_IMAGE_WIDTH, pick_width());
        width_written = 1'b1;
      end
      if (choice >= 4 || first_phase) write_reg(REG_IMAGE_HEIGHT, pick_height());
      if (first_phase) begin
        // block fills up behind a long result hold-off
        burst_mode = 1'b1;
        n = 150;
        run_phase(n, 1'b1, 0, 1'b0, 20);
        first_phase = 1'b0;
      end else begin
        burst_mode = ($urandom_range(0, 4) == 0);
        n = $urandom_range(15, 70);
        run_phase(n, width_written || $urandom_range(0, 1), $urandom_range(0, 2), 1'b1, -1);
      end
      random_items += n;
      settle();
    end

    // widest line, written above the maximum; a short run along the first line
    write_reg(REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    burst_mode = 1'b0;
    run_phase(PROBE_ITEMS, 1'b1, 0, 1'b0, -1);
    settle();

    // narrowest line, height written above the maximum; the first few lines only
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd1025);
    run_phase(PROBE_ITEMS, 1'b1, 1, 1'b0, -1);
    settle();

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sem_pkg.sv
rtl/sem_root_cell.sv
rtl/sem_line_window.sv
rtl/sobel_edge_magnitude_top.sv
test/sobel_edge_checker.sv
test/sobel_edge_magnitude_top_test.sv
